[rtl/core/pds_pkg.sv]
// pds_pkg: shared types and constants for the packet deframer.
// Holds the controller state encoding and the command/status structs.
// No dependencies.
package pds_pkg;

  // Largest payload a frame may carry, and the widths that follow from it
  localparam int unsigned MAX_PAYLOAD = 32;
  localparam int unsigned ADDR_W      = 5;   // payload store index
  localparam int unsigned LEN_W       = 6;   // length / count, holds MAX_PAYLOAD
  localparam int unsigned BYTE_W      = 8;

  localparam logic [BYTE_W-1:0] MARKER_RST = 8'hAA;
  localparam logic [BYTE_W-1:0] MAX_LEN    = 8'(MAX_PAYLOAD);

  // Controller states, one-hot
  typedef enum logic [6:0] {
    S_HUNT = 7'b0000001,
    S_TYPE = 7'b0000010,
    S_LEN  = 7'b0000100,
    S_SUM  = 7'b0001000,
    S_DATA = 7'b0010000,
    S_RD   = 7'b0100000,
    S_OUT  = 7'b1000000
  } pds_state_t;

  // Controller to datapath
  typedef struct packed {
    logic ld_type;   // capture type byte
    logic ld_len;    // capture length, seed sum, clear counters
    logic ld_sum;    // capture checksum byte
    logic wr_data;   // store payload beat, accumulate
    logic rd;        // read payload store at current index
    logic inc_idx;   // advance output index
  } pds_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_marker;   // incoming byte equals start marker
    logic len_big;     // incoming length exceeds MAX_PAYLOAD
    logic len_zero;    // held length is zero
    logic zero_ok;     // empty frame: checksum byte matches
    logic data_done;   // this payload beat completes the frame
    logic data_ok;     // running sum including this beat matches
    logic idx_last;    // current result is the last of the frame
  } pds_stat_t;

endpackage

[rtl/core/packet_deframer_sum_check.sv]
// packet_deframer_sum_check: top level of the byte-serial packet deframer.
// Joins pds_ctrl and pds_dp; holds the port-level assertions.
// Depends on pds_pkg, pds_ctrl, pds_dp.

// Received bytes are taken one a cycle while a frame is being gathered: the
// block hunts for the start marker, then reads type, length and checksum
// bytes and stores up to MAX_PAYLOAD (32) payload bytes. When the frame's last
// byte arrives and length plus payload sum (modulo 256) equals the checksum,
// the frame is delivered one result per payload byte, or as a single empty-frame
// result for length zero; a bad checksum or oversized length drops the frame
// silently. Each payload result is a read of the payload store (S_RD) then the
// output state (S_OUT), held while out_stall is high; in_stall is high all
// through delivery. The user is to write the start marker through the cfg port
// (ready always high) only while idle; the block does not enforce it.
module packet_deframer_sum_check (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [pds_pkg::BYTE_W-1:0] in_rx_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [pds_pkg::BYTE_W-1:0] out_frame_type,
  output logic [pds_pkg::LEN_W-1:0]  out_frame_length,
  output logic [pds_pkg::ADDR_W-1:0] out_byte_index,
  output logic [pds_pkg::BYTE_W-1:0] out_payload_byte,
  output logic                       out_empty_frame,
  output logic                       out_last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [pds_pkg::BYTE_W-1:0] cfg_start_marker
);
  import pds_pkg::*;

  pds_cmd_t  cmd;
  pds_stat_t stat;

  assign cfg_ready = 1'b1;

  pds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pds_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_byte      (in_rx_byte),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_start_marker),
    .cmd          (cmd),
    .stat         (stat),
    .frame_type   (out_frame_type),
    .frame_length (out_frame_length),
    .byte_index   (out_byte_index),
    .payload_byte (out_payload_byte),
    .empty_frame  (out_empty_frame),
    .last         (out_last)
  );

  // Input is held off while a result beat is on offer
  a_stall_on_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input not stalled during emission");

  // An empty frame is always a single beat
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_frame) |-> out_last)
    else $error("empty frame result without last");

  // Payload index stays within the frame
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_empty_frame) |-> (6'(out_byte_index) < out_frame_length))
    else $error("byte index beyond frame length");

  // After the last beat is taken the block goes back to hunting
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last && !out_stall) |=> !out_valid)
    else $error("result beat after end of frame");

endmodule

[rtl/core/pds_ctrl.sv]
// pds_ctrl: frame controller state machine.
// Sequences hunt, header, payload capture and result emission.
// Depends on pds_pkg.
module pds_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  pds_pkg::pds_stat_t stat,
  output pds_pkg::pds_cmd_t  cmd
);
  import pds_pkg::*;

  pds_state_t state_r, state_nxt;
  logic       in_acc;

  assign in_stall  = (state_r == S_RD) || (state_r == S_OUT);
  assign out_valid = (state_r == S_OUT);
  assign in_acc    = in_valid && !in_stall;

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_HUNT: begin
        if (in_acc && stat.is_marker) state_nxt = S_TYPE;
      end
      S_TYPE: begin
        if (in_acc) begin
          cmd.ld_type = 1'b1;
          state_nxt   = S_LEN;
        end
      end
      S_LEN: begin
        if (in_acc) begin
          if (stat.len_big) begin
            state_nxt = S_HUNT;
          end else begin
            cmd.ld_len = 1'b1;
            state_nxt  = S_SUM;
          end
        end
      end
      S_SUM: begin
        if (in_acc) begin
          cmd.ld_sum = 1'b1;
          if (!stat.len_zero)    state_nxt = S_DATA;
          else if (stat.zero_ok) state_nxt = S_OUT;
          else                   state_nxt = S_HUNT;
        end
      end
      S_DATA: begin
        if (in_acc) begin
          cmd.wr_data = 1'b1;
          if (stat.data_done) state_nxt = stat.data_ok ? S_RD : S_HUNT;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          if (stat.idx_last) begin
            state_nxt = S_HUNT;
          end else begin
            cmd.inc_idx = 1'b1;
            state_nxt   = S_RD;
          end
        end
      end
      default: state_nxt = S_HUNT;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/core/pds_dp.sv]
// pds_dp: deframer datapath: header registers, checksum, payload store.
// Driven by pds_ctrl commands; reports compare results back as status.
// Depends on pds_pkg.
module pds_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [pds_pkg::BYTE_W-1:0]  rx_byte,
  input  logic                        cfg_we,
  input  logic [pds_pkg::BYTE_W-1:0]  cfg_data,
  input  pds_pkg::pds_cmd_t           cmd,
  output pds_pkg::pds_stat_t          stat,
  output logic [pds_pkg::BYTE_W-1:0]  frame_type,
  output logic [pds_pkg::LEN_W-1:0]   frame_length,
  output logic [pds_pkg::ADDR_W-1:0]  byte_index,
  output logic [pds_pkg::BYTE_W-1:0]  payload_byte,
  output logic                        empty_frame,
  output logic                        last
);
  import pds_pkg::*;

  logic [BYTE_W-1:0] marker_r;
  logic [BYTE_W-1:0] type_r;
  logic [LEN_W-1:0]  len_r;
  logic [BYTE_W-1:0] exp_r;
  logic [BYTE_W-1:0] sum_r;
  logic [LEN_W-1:0]  cnt_r;
  logic [ADDR_W-1:0] idx_r;
  logic [BYTE_W-1:0] rd_data_r;
  logic [BYTE_W-1:0] mem [MAX_PAYLOAD];

  logic [BYTE_W-1:0] sum_nxt;
  logic [LEN_W-1:0]  cnt_inc;

  assign sum_nxt = sum_r + rx_byte;
  assign cnt_inc = cnt_r + LEN_W'(1);

  // Start marker register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= MARKER_RST;
    end else if (cfg_we) begin
      marker_r <= cfg_data;
    end
  end

  // Header, checksum and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_r <= '0;
      len_r  <= '0;
      exp_r  <= '0;
      sum_r  <= '0;
      cnt_r  <= '0;
      idx_r  <= '0;
    end else begin
      if (cmd.ld_type) type_r <= rx_byte;
      if (cmd.ld_len) begin
        len_r <= rx_byte[LEN_W-1:0];
        sum_r <= rx_byte;
        cnt_r <= '0;
        idx_r <= '0;
      end
      if (cmd.ld_sum) exp_r <= rx_byte;
      if (cmd.wr_data) begin
        sum_r <= sum_nxt;
        cnt_r <= cnt_inc;
      end
      if (cmd.inc_idx) idx_r <= idx_r + ADDR_W'(1);
    end
  end

  // Payload store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_data) mem[cnt_r[ADDR_W-1:0]] <= rx_byte;
    if (cmd.rd)      rd_data_r <= mem[idx_r];
  end

  // Status back to the controller
  always_comb begin
    stat.is_marker = (rx_byte == marker_r);
    stat.len_big   = (rx_byte > MAX_LEN);
    stat.len_zero  = (len_r == '0);
    stat.zero_ok   = (rx_byte == sum_r);
    stat.data_done = (cnt_inc >= len_r);
    stat.data_ok   = (sum_nxt == exp_r);
    stat.idx_last  = (len_r == '0) || ((LEN_W'(idx_r) + LEN_W'(1)) == len_r);
  end

  // Result fields
  assign frame_type   = type_r;
  assign frame_length = len_r;
  assign byte_index   = idx_r;
  assign empty_frame  = (len_r == '0);
  assign payload_byte = empty_frame ? '0 : rd_data_r;
  assign last         = stat.idx_last;

endmodule

[dv/tb_packet_deframer_sum_check.sv]
// tb_packet_deframer_sum_check: self-checking testbench for the packet deframer.
// Drives bytes under random stalls and gaps, predicts result beats, compares them.
// Depends on pds_pkg and packet_deframer_sum_check.
module tb_packet_deframer_sum_check;
  timeunit 1ns;
  timeprecision 1ps;

  import pds_pkg::*;

  localparam int DIR_ROWS     = 25;
  localparam int DRAIN_CYCLES = 80;

  // One result beat, field for field as on the out_ ports
  typedef struct packed {
    logic [BYTE_W-1:0] ftype;
    logic [LEN_W-1:0]  flen;
    logic [ADDR_W-1:0] idx;
    logic [BYTE_W-1:0] pbyte;
    logic              empty;
    logic              is_last;
  } frame_beat_t;

  // Directed row: input byte, plus a hand-written beat where it is obvious
  typedef struct packed {
    logic [BYTE_W-1:0] rx;
    logic              typed;
    frame_beat_t       beat;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] out_frame_type;
  logic [LEN_W-1:0]  out_frame_length;
  logic [ADDR_W-1:0] out_byte_index;
  logic [BYTE_W-1:0] out_payload_byte;
  logic              out_empty_frame;
  logic              out_last;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [BYTE_W-1:0] cfg_start_marker = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;

  // Predictor state
  logic [BYTE_W-1:0] start_byte = MARKER_RST;
  pds_state_t        dfr_state = S_HUNT;
  logic [BYTE_W-1:0] cur_type = '0;
  logic [BYTE_W-1:0] cur_len = '0;
  logic [BYTE_W-1:0] want_sum = '0;
  logic [BYTE_W-1:0] acc_sum = '0;
  logic [LEN_W-1:0]  got_count = '0;
  logic [BYTE_W-1:0] stash [MAX_PAYLOAD];

  frame_beat_t fresh_beats[$];
  frame_beat_t frame_beats_due[$];

  // Directed traffic, marker at its reset value
  stim_row_t dir_rows [DIR_ROWS] = '{
    // empty frame with zero checksum
    '{8'hAA, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, {8'h00, 6'd0, 5'd0, 8'h00, 1'b1, 1'b1}},
    // one byte of all ones, sum wraps to zero
    '{8'hAA, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'h01, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b1, {8'hFF, 6'd1, 5'd0, 8'hFF, 1'b0, 1'b1}},
    // length one past the limit, then the largest length byte
    '{8'hAA, 1'b0, '0}, '{8'h12, 1'b0, '0}, '{8'h21, 1'b0, '0},
    '{8'hAA, 1'b0, '0}, '{8'h77, 1'b0, '0}, '{8'hFF, 1'b0, '0},
    // empty frame with bad checksum is dropped
    '{8'hAA, 1'b0, '0}, '{8'h05, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h01, 1'b0, '0},
    // marker value used as type byte, two payload bytes
    '{8'hAA, 1'b0, '0}, '{8'hAA, 1'b0, '0}, '{8'h02, 1'b0, '0}, '{8'h32, 1'b0, '0},
    '{8'h10, 1'b0, '0}, '{8'h20, 1'b0, '0}
  };

  packet_deframer_sum_check i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_type   (out_frame_type),
    .out_frame_length (out_frame_length),
    .out_byte_index   (out_byte_index),
    .out_payload_byte (out_payload_byte),
    .out_empty_frame  (out_empty_frame),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_start_marker (cfg_start_marker)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Frame complete: back to hunting, emit beats if the sum matches
  function automatic void close_frame();
    dfr_state = S_HUNT;
    if (acc_sum == want_sum) begin
      if (cur_len == 0) begin
        fresh_beats.push_back({cur_type, 6'd0, 5'd0, 8'h00, 1'b1, 1'b1});
      end else begin
        for (int k = 0; k < cur_len; k++) begin
          fresh_beats.push_back({cur_type, cur_len[LEN_W-1:0], ADDR_W'(k), stash[k],
                                 1'b0, (k + 1 == cur_len)});
        end
      end
    end
  endfunction

  // Advance the deframer by one received byte
  function automatic void deframe_step(logic [BYTE_W-1:0] b);
    case (dfr_state)
      S_TYPE: begin
        cur_type  = b;
        dfr_state = S_LEN;
      end
      S_LEN: begin
        if (b > MAX_LEN) begin
          dfr_state = S_HUNT;
        end else begin
          cur_len   = b;
          acc_sum   = b;
          got_count = '0;
          dfr_state = S_SUM;
        end
      end
      S_SUM: begin
        want_sum  = b;
        dfr_state = S_DATA;
        if (cur_len == 0) close_frame();
      end
      S_DATA: begin
        if (got_count < MAX_PAYLOAD) begin
          stash[got_count[ADDR_W-1:0]] = b;
          acc_sum   = acc_sum + b;
          got_count = got_count + 1'b1;
        end
        if (got_count >= cur_len) close_frame();
      end
      default: begin
        dfr_state = (b == start_byte) ? S_TYPE : S_HUNT;
      end
    endcase
  endfunction

  // Offer one byte, hold it until taken, then queue what it produces
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed,
                           input frame_beat_t typed_beat);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      repeat ($urandom_range(1, 4)) begin
        @(negedge clk);
        in_valid   <= 1'b0;
        in_rx_byte <= 8'($urandom);
      end
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    fresh_beats.delete();
    deframe_step(b);
    if (typed) begin
      frame_beats_due.push_back(typed_beat);
    end else begin
      foreach (fresh_beats[i]) frame_beats_due.push_back(fresh_beats[i]);
    end
  endtask

  // Drop valid, wait for every beat, then let dropped frames finish
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (frame_beats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_marker(input logic [BYTE_W-1:0] v);
    @(negedge clk);
    cfg_valid        <= 1'b1;
    cfg_start_marker <= v;
    do @(posedge clk); while (!cfg_ready);
    start_byte = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed frames, some with bad sums, oversize lengths or noise
  task automatic run_traffic(input int n_bytes, input bit with_full);
    int                sent;
    int                pick;
    int                flen;
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] bt;
    logic [BYTE_W-1:0] burst[$];
    logic [BYTE_W-1:0] body[$];
    sent = 0;
    while (sent < n_bytes) begin
      burst.delete();
      body.delete();
      repeat ($urandom_range(0, 2)) begin
        do bt = 8'($urandom); while (bt == start_byte);
        burst.push_back(bt);
      end
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        // raw noise, may contain the marker and leave a frame half-read
        repeat ($urandom_range(1, 4)) burst.push_back(8'($urandom));
      end else begin
        burst.push_back(start_byte);
        burst.push_back(8'($urandom));
        if (pick < 14) begin
          burst.push_back(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
        end else begin
          if (with_full && sent == 0) flen = MAX_PAYLOAD;
          else if ($urandom_range(0, 9) == 0) flen = 0;
          else if ($urandom_range(0, 19) == 0) flen = MAX_PAYLOAD;
          else flen = $urandom_range(1, 6);
          sum = 8'(flen);
          repeat (flen) begin
            bt = 8'($urandom);
            body.push_back(bt);
            sum = sum + bt;
          end
          if (pick < 22) sum = sum ^ 8'($urandom_range(1, 255));
          burst.push_back(8'(flen));
          burst.push_back(sum);
          foreach (body[i]) burst.push_back(body[i]);
        end
      end
      foreach (burst[i]) send_byte(burst[i], 1'b0, '0);
      sent += burst.size();
    end
  endtask

  function automatic void check_field(string name, logic [BYTE_W-1:0] want,
                                      logic [BYTE_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Receiver stalls
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Result beats against the oldest expectation
  always @(posedge clk) begin
    frame_beat_t exp_beat;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_beats_due.size() == 0) begin
        $display("%0t ns: beat with nothing expected, type %0h index %0d byte %0h",
                 $time, out_frame_type, out_byte_index, out_payload_byte);
        errors++;
      end else begin
        exp_beat = frame_beats_due.pop_front();
        check_field("frame_type",   exp_beat.ftype,   out_frame_type);
        check_field("frame_length", 8'(exp_beat.flen), 8'(out_frame_length));
        check_field("byte_index",   8'(exp_beat.idx),  8'(out_byte_index));
        check_field("payload_byte", exp_beat.pbyte,   out_payload_byte);
        check_field("empty_frame",  8'(exp_beat.empty), 8'(out_empty_frame));
        check_field("last",         8'(exp_beat.is_last), 8'(out_last));
      end
    end
  end

  initial begin
    #4_000_000;
    $display("packet_deframer_sum_check: mismatch");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // sender idles lightly, receiver heavily
    send_idle_pct = 19;
    recv_idle_pct = 49;
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].beat);
    end
    settle();
    write_marker(8'h00);
    run_traffic(40, 1'b1);
    settle();

    // the other way round
    send_idle_pct = 49;
    recv_idle_pct = 19;
    write_marker(8'hFF);
    run_traffic(40, 1'b0);
    settle();

    // back to back
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_marker(8'($urandom));
    run_traffic(40, 1'b0);
    settle();

    if (errors == 0) begin
      $display("packet_deframer_sum_check: match");
    end else begin
      $display("packet_deframer_sum_check: mismatch");
    end
    $finish;
  end

endmodule

[packet_deframer_sum_check.f]
rtl/core/pds_pkg.sv
rtl/core/pds_ctrl.sv
rtl/core/pds_dp.sv
rtl/core/packet_deframer_sum_check.sv
dv/tb_packet_deframer_sum_check.sv
